FILE: rtl/iorb_pkg.sv
package iorb_pkg;

    localparam int WINDOW   = 32;
    localparam int ID_BITS  = 16;
    localparam int PAY_BITS = 32;
    localparam int HEAD_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_SKIP    = 2'd1,
        KIND_STALE   = 2'd2,
        KIND_BEYOND  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CLS_RELEASE = 2'd0,
        CLS_HOLD    = 2'd1,
        CLS_STALE   = 2'd2,
        CLS_BEYOND  = 2'd3
    } t_cls;

    typedef struct packed {
        logic capture;
        logic hold_wr;
        logic emit_first;
        logic emit_drain;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic next_held;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/iorb_ctrl.sv
module iorb_ctrl import iorb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.cls == CLS_HOLD) begin
                    o_cmd.hold_wr = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_first = 1'b1;
                    if (i_status.cls == CLS_RELEASE && i_status.next_held) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_drain = 1'b1;
                    if (!i_status.next_held) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/iorb_dp.sv
module iorb_dp import iorb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_op,
    input  logic [ID_BITS-1:0]  i_order_id,
    input  logic [PAY_BITS-1:0] i_payload,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [ID_BITS-1:0]  o_out_id,
    output logic [PAY_BITS-1:0] o_out_payload,
    output logic [1:0]          o_kind,
    output logic                o_last
);

    logic                r_in_op;
    logic [ID_BITS-1:0]  r_in_id;
    logic [PAY_BITS-1:0] r_in_payload;

    logic [ID_BITS-1:0]  r_next;
    logic [HEAD_W-1:0]   r_head;
    logic [WINDOW-1:0]   r_held;
    logic [WINDOW-1:0]   r_aband;
    logic [PAY_BITS-1:0] r_slot_pay [WINDOW];

    logic                r_out_valid;
    logic [ID_BITS-1:0]  r_out_id;
    logic [PAY_BITS-1:0] r_out_payload;
    t_kind               r_out_kind;
    logic                r_out_last;

    logic [ID_BITS-1:0]  w_dist;
    t_cls                w_cls;
    logic [HEAD_W-1:0]   w_head_inc;
    logic [HEAD_W:0]     w_sum;
    logic [HEAD_W-1:0]   w_hold_idx;
    logic                w_next_held;
    logic                w_out_free;

    assign w_dist = r_in_id - r_next;

    always_comb begin
        if (w_dist == '0) begin
            w_cls = CLS_RELEASE;
        end else if (w_dist < ID_BITS'(WINDOW)) begin
            w_cls = CLS_HOLD;
        end else if (w_dist[ID_BITS-1]) begin
            w_cls = CLS_STALE;
        end else begin
            w_cls = CLS_BEYOND;
        end
    end

    assign w_head_inc = (r_head == HEAD_W'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign w_sum      = (HEAD_W + 1)'(r_head) + (HEAD_W + 1)'(w_dist[HEAD_W-1:0]);
    assign w_hold_idx = (w_sum >= (HEAD_W + 1)'(WINDOW))
                        ? HEAD_W'(w_sum - (HEAD_W + 1)'(WINDOW))
                        : w_sum[HEAD_W-1:0];
    assign w_next_held = r_held[w_head_inc];
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_status.cls       = w_cls;
    assign o_status.next_held = w_next_held;
    assign o_status.out_free  = w_out_free;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op      <= i_op;
            r_in_id      <= i_order_id;
            r_in_payload <= i_payload;
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next  <= '0;
            r_head  <= '0;
            r_held  <= '0;
            r_aband <= '0;
        end else begin
            if (i_cmd.hold_wr) begin
                r_held[w_hold_idx]  <= 1'b1;
                r_aband[w_hold_idx] <= r_in_op;
            end
            if (i_cmd.emit_drain) begin
                r_held[r_head]  <= 1'b0;
                r_aband[r_head] <= 1'b0;
            end
            if ((i_cmd.emit_first && w_cls == CLS_RELEASE) || i_cmd.emit_drain) begin
                r_next <= r_next + 1'b1;
                r_head <= w_head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_wr) begin
            r_slot_pay[w_hold_idx] <= r_in_op ? '0 : r_in_payload;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_first || i_cmd.emit_drain) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_first) begin
            r_out_id <= r_in_id;
            case (w_cls)
                CLS_RELEASE: begin
                    r_out_payload <= r_in_op ? '0 : r_in_payload;
                    r_out_kind    <= r_in_op ? KIND_SKIP : KIND_PAYLOAD;
                end
                CLS_STALE: begin
                    r_out_payload <= '0;
                    r_out_kind    <= KIND_STALE;
                end
                default: begin
                    r_out_payload <= '0;
                    r_out_kind    <= KIND_BEYOND;
                end
            endcase
            r_out_last <= !(w_cls == CLS_RELEASE && w_next_held);
        end else if (i_cmd.emit_drain) begin
            r_out_id      <= r_next;
            r_out_payload <= r_aband[r_head] ? '0 : r_slot_pay[r_head];
            r_out_kind    <= r_aband[r_head] ? KIND_SKIP : KIND_PAYLOAD;
            r_out_last    <= !w_next_held;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_id      = r_out_id;
    assign o_out_payload = r_out_payload;
    assign o_kind        = r_out_kind;
    assign o_last        = r_out_last;

endmodule

FILE: rtl/in_order_release_reorder_buffer.sv
// in-order release reorder buffer
// input channel: i_in_valid / o_in_stall with i_op, i_order_id, i_payload;
// a transaction is taken at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall with o_out_id, o_out_payload,
// o_kind, o_last; o_last marks the final result of one input transaction
// an item with the expected number is released, then held entries with the
// following numbers drain one per cycle while the output is not stalled; items
// less than the window ahead are held with no result; stale or too-far numbers
// give one rejection result; an input transaction is captured, then evaluated,
// then held entries drain in order; the first result is registered on evaluate
// the output register lets the next transaction be captured while a result
// waits; a stall on the output holds the result and pauses the drain sequencer
// reset (synchronous, active low) empties the window and sets the expected
// number to zero; no clearing pass is needed
module in_order_release_reorder_buffer import iorb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_op,
    input  logic [ID_BITS-1:0]  i_order_id,
    input  logic [PAY_BITS-1:0] i_payload,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [ID_BITS-1:0]  o_out_id,
    output logic [PAY_BITS-1:0] o_out_payload,
    output logic [1:0]          o_kind,
    output logic                o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    iorb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    iorb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_op          (i_op),
        .i_order_id    (i_order_id),
        .i_payload     (i_payload),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_id      (o_out_id),
        .o_out_payload (o_out_payload),
        .o_kind        (o_kind),
        .o_last        (o_last)
    );

endmodule

FILE: tb/sv/in_order_release_reorder_buffer_tb.sv
module in_order_release_reorder_buffer_tb;
    import iorb_pkg::*;

    localparam int N_ITEMS = 380;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTS = 40;
    localparam bit OP_PAYLOAD = 1'b0;
    localparam bit OP_ABANDON = 1'b1;
    localparam logic [ID_BITS-1:0] ID_HALF = ID_BITS'(1 << (ID_BITS - 1));

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [PAY_BITS-1:0] pay;
        t_kind               kind;
        logic                last;
    } t_release;

    typedef struct packed {
        bit                op;
        bit [ID_BITS-1:0]  id;
        bit [PAY_BITS-1:0] pay;
        bit                typed;
        t_kind             kind;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_op = 1'b0;
    logic [ID_BITS-1:0]  i_order_id = '0;
    logic [PAY_BITS-1:0] i_payload = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [ID_BITS-1:0]  o_out_id;
    logic [PAY_BITS-1:0] o_out_payload;
    logic [1:0]          o_kind;
    logic                o_last;

    // reorder state mirror
    logic [ID_BITS-1:0]  nexp;
    logic                slot_held [WINDOW];
    logic                slot_aband [WINDOW];
    logic [PAY_BITS-1:0] slot_pay [WINDOW];
    int                  hd;

    t_release step_q [$];
    t_release release_q [$];
    int       n_err = 0;
    int       n_sent = 0;
    int       idle_cycles = 0;
    int       stall_left = 0;
    bit       quiet = 1'b0;

    // directed rows: expected result typed in where it is obvious
    t_dir_row dir_tab [16] = '{
        '{OP_PAYLOAD, 16'h0000, 32'hFFFF_FFFF, 1'b1, KIND_PAYLOAD},
        '{OP_ABANDON, 16'h0001, 32'hFFFF_FFFF, 1'b1, KIND_SKIP},
        '{OP_PAYLOAD, 16'h0000, 32'h1234_5678, 1'b1, KIND_STALE},
        '{OP_PAYLOAD, 16'h0022, 32'hAAAA_AAAA, 1'b1, KIND_BEYOND},
        '{OP_ABANDON, 16'h0021, 32'h0000_0000, 1'b0, KIND_PAYLOAD},
        '{OP_PAYLOAD, 16'h8002, 32'h0000_0000, 1'b1, KIND_STALE},
        '{OP_PAYLOAD, 16'h8001, 32'hFFFF_FFFF, 1'b1, KIND_BEYOND},
        '{OP_PAYLOAD, 16'h0003, 32'h0000_0000, 1'b0, KIND_PAYLOAD},
        '{OP_PAYLOAD, 16'h0003, 32'h5555_AAAA, 1'b0, KIND_PAYLOAD},
        '{OP_ABANDON, 16'h0004, 32'h0000_0000, 1'b0, KIND_PAYLOAD},
        '{OP_PAYLOAD, 16'h0004, 32'hDEAD_BEEF, 1'b0, KIND_PAYLOAD},
        '{OP_PAYLOAD, 16'h0005, 32'h0000_0001, 1'b0, KIND_PAYLOAD},
        '{OP_ABANDON, 16'h0005, 32'h7777_7777, 1'b0, KIND_PAYLOAD},
        '{OP_PAYLOAD, 16'h0002, 32'h8000_0000, 1'b0, KIND_PAYLOAD},
        '{OP_PAYLOAD, 16'hFFFF, 32'h0F0F_0F0F, 1'b1, KIND_STALE},
        '{OP_ABANDON, 16'h0006, 32'h0000_0000, 1'b1, KIND_SKIP}
    };

    in_order_release_reorder_buffer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_order_id   (i_order_id),
        .i_payload    (i_payload),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_id     (o_out_id),
        .o_out_payload(o_out_payload),
        .o_kind       (o_kind),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reorder_reset();
        nexp = '0;
        hd = 0;
        for (int i = 0; i < WINDOW; i++) begin
            slot_held[i] = 1'b0;
            slot_aband[i] = 1'b0;
            slot_pay[i] = '0;
        end
    endfunction

    function automatic void push_release(logic [ID_BITS-1:0] id, logic [PAY_BITS-1:0] pay,
                                         t_kind kind);
        t_release r;
        r.id = id;
        r.pay = pay;
        r.kind = kind;
        r.last = 1'b0;
        step_q.insert(step_q.size(), r);
    endfunction

    function automatic void advance_head();
        nexp = nexp + 1'b1;
        hd = (hd + 1) % WINDOW;
    endfunction

    // results caused by one accepted transaction, into step_q
    function automatic void reorder_predict(bit op, logic [ID_BITS-1:0] id,
                                            logic [PAY_BITS-1:0] pay);
        logic [ID_BITS-1:0] d;
        int idx;
        step_q.delete();
        d = id - nexp;
        if (d == 0) begin
            push_release(id, op ? '0 : pay, op ? KIND_SKIP : KIND_PAYLOAD);
            advance_head();
            while (step_q.size() < WINDOW && slot_held[hd]) begin
                if (slot_aband[hd])
                    push_release(nexp, '0, KIND_SKIP);
                else
                    push_release(nexp, slot_pay[hd], KIND_PAYLOAD);
                slot_held[hd] = 1'b0;
                slot_aband[hd] = 1'b0;
                advance_head();
            end
        end else if (d < WINDOW) begin
            idx = (hd + int'(d)) % WINDOW;
            slot_held[idx] = 1'b1;
            slot_aband[idx] = op;
            slot_pay[idx] = op ? '0 : pay;
        end else if (d >= ID_HALF) begin
            push_release(id, '0, KIND_STALE);
        end else begin
            push_release(id, '0, KIND_BEYOND);
        end
        if (step_q.size() != 0)
            step_q[step_q.size()-1].last = 1'b1;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit rand_op();
        return $urandom_range(0, 3) == 0;
    endfunction

    function automatic logic [PAY_BITS-1:0] rand_pay();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return '0;
        if (p == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic flag_err(string what);
        n_err++;
        if (n_err <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic send_item(bit op, logic [ID_BITS-1:0] id, logic [PAY_BITS-1:0] pay,
                             bit typed, t_kind tk);
        int gap;
        t_release r;
        gap = gap_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_order_id <= id;
        i_payload <= pay;
        do @(posedge i_clk); while (o_in_stall);
        reorder_predict(op, id, pay);
        if (typed) begin
            r.id = id;
            r.pay = (tk == KIND_PAYLOAD) ? pay : '0;
            r.kind = tk;
            r.last = 1'b1;
            release_q.insert(release_q.size(), r);
        end else begin
            foreach (step_q[k])
                release_q.insert(release_q.size(), step_q[k]);
        end
        n_sent++;
    endtask

    // holds ahead of the expected number in random order, at times one hold repeated, then the release if complete
    task automatic burst_seq(int k, bit complete);
        int ds [WINDOW-1];
        int j;
        int tmp;
        logic [ID_BITS-1:0] base;
        base = nexp;
        for (int i = 0; i < WINDOW - 1; i++)
            ds[i] = i + 1;
        for (int i = WINDOW - 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = ds[i];
            ds[i] = ds[j];
            ds[j] = tmp;
        end
        for (int i = 0; i < k - 1; i++)
            send_item(rand_op(), ID_BITS'(base + ds[i]), rand_pay(), 1'b0, KIND_PAYLOAD);
        if (k > 1 && $urandom_range(0, 4) == 0)
            send_item(rand_op(), ID_BITS'(base + ds[$urandom_range(0, k - 2)]), rand_pay(),
                      1'b0, KIND_PAYLOAD);
        if (complete)
            send_item(rand_op(), base, rand_pay(), 1'b0, KIND_PAYLOAD);
    endtask

    task automatic noise_item();
        logic [ID_BITS-1:0] id;
        case ($urandom_range(0, 5))
            0: id = nexp + ID_BITS'(WINDOW);
            1: id = nexp + ID_HALF;
            2: id = nexp + ID_HALF - 1'b1;
            3: id = nexp - 1'b1;
            default: id = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
        endcase
        send_item(rand_op(), id, rand_pay(), 1'b0, KIND_PAYLOAD);
    endtask

    function automatic int burst_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(1, 4);
        if (p < 95)
            return $urandom_range(5, 12);
        return $urandom_range(13, WINDOW);
    endfunction

    // result check, output stall and watchdog
    always @(posedge i_clk) begin
        t_release r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (release_q.size() == 0) begin
                flag_err($sformatf("unexpected result id %h", o_out_id));
            end else begin
                r = release_q.pop_front();
                if (o_out_id !== r.id)
                    flag_err($sformatf("id %h, want %h", o_out_id, r.id));
                if (o_out_payload !== r.pay)
                    flag_err($sformatf("payload %h, want %h (id %h)", o_out_payload, r.pay,
                                       r.id));
                if (o_kind !== r.kind)
                    flag_err($sformatf("kind %0d, want %0d (id %h)", o_kind, r.kind, r.id));
                if (o_last !== r.last)
                    flag_err($sformatf("last %b, want %b (id %h)", o_last, r.last, r.id));
            end
        end

        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                stall_left <= gap_len();
        end

        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int p;
        reorder_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].id, dir_tab[i].pay, dir_tab[i].typed,
                      dir_tab[i].kind);

        // full window, then the mixed random part
        burst_seq(WINDOW, 1'b1);
        while (n_sent < N_ITEMS) begin
            if ($urandom_range(0, 29) == 0)
                quiet = !quiet;
            p = $urandom_range(0, 99);
            if (p < 50)
                burst_seq(burst_len(), $urandom_range(0, 9) != 0);
            else if (p < 70)
                send_item(rand_op(), nexp, rand_pay(), 1'b0, KIND_PAYLOAD);
            else if (p < 85)
                send_item(rand_op(), nexp + ID_BITS'($urandom_range(1, WINDOW - 1)),
                          rand_pay(), 1'b0, KIND_PAYLOAD);
            else
                noise_item();
        end
        i_in_valid <= 1'b0;

        while (release_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/iorb_pkg.sv
rtl/iorb_ctrl.sv
rtl/iorb_dp.sv
rtl/in_order_release_reorder_buffer.sv
tb/sv/in_order_release_reorder_buffer_tb.sv
